// ===== rtl/core/b32e_pkg.sv =====
// ----------------------------------------------------------------------------
// b32e_pkg
// Shared types, constants and the symbol mapping for the base32 encoder.
// ----------------------------------------------------------------------------
package b32e_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned SYM_W     = 5;
  localparam int unsigned MAX_CHARS = 3;   // two data characters and one flush

  localparam logic [CHAR_W-1:0] PAD_CHAR    = 8'h3D;  // '='
  localparam logic [CHAR_W-1:0] CHAR_A      = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CHAR_TWO    = 8'h32;  // '2'
  localparam logic [SYM_W-1:0]  ALPHA_SPLIT = 5'd26;

  // One byte's worth of work for the back end: the characters it must send,
  // how many, and whether the message ends (padding and last flag follow).
  typedef struct packed {
    logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
    logic [1:0]                       cnt;
    logic                             eom;
  } b32e_cmd_t;

  function automatic logic [CHAR_W-1:0] symbol_char(input logic [SYM_W-1:0] v);
    logic [CHAR_W-1:0] ch;
    if (v < ALPHA_SPLIT) begin
      ch = CHAR_A + {3'd0, v};
    end else begin
      ch = CHAR_TWO + {3'd0, v - ALPHA_SPLIT};
    end
    return ch;
  endfunction

endpackage

// ===== rtl/core/b32e_front.sv =====
// ----------------------------------------------------------------------------
// b32e_front
// Accepts bytes, splits them into 5-bit symbols and builds back-end commands.
// ----------------------------------------------------------------------------
module b32e_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [7:0]          in_data_byte,
  input  logic                in_end_of_message,
  input  logic                take,
  output b32e_pkg::b32e_cmd_t cmd
);
  import b32e_pkg::*;

  logic [3:0]  left_bits_r, left_bits_nxt;
  logic [2:0]  left_cnt_r,  left_cnt_nxt;
  logic [11:0] acc;
  logic [3:0]  nbits;
  logic [3:0]  sh0;
  logic [3:0]  sh1;
  logic        two;
  logic [3:0]  rem;
  logic [11:0] rem_mask;
  logic [3:0]  rem_bits;
  logic [7:0]  c0, c1, cf;
  logic        has_flush;

  assign acc   = {left_bits_r, in_data_byte};
  assign nbits = 4'd8 + {1'b0, left_cnt_r};
  assign two   = (nbits >= 4'd10);
  assign sh0   = nbits - 4'd5;
  assign sh1   = nbits - 4'd10;
  assign rem   = two ? sh1 : sh0;
  assign rem_mask = (12'd1 << rem) - 12'd1;
  assign rem_bits = 4'((acc & rem_mask));

  assign c0 = symbol_char(5'((acc >> sh0)));
  assign c1 = symbol_char(5'((acc >> sh1)));
  // Left-align the leftover into a full symbol for the flush character.
  assign cf = symbol_char(5'(({1'b0, rem_bits} << (4'd5 - rem))));
  assign has_flush = in_end_of_message && (rem != 4'd0);

  always_comb begin
    cmd.chars[0] = c0;
    cmd.chars[1] = two ? c1 : cf;
    cmd.chars[2] = cf;
    cmd.cnt      = (two ? 2'd2 : 2'd1) + {1'b0, has_flush};
    cmd.eom      = in_end_of_message;
  end

  always_comb begin
    left_bits_nxt = left_bits_r;
    left_cnt_nxt  = left_cnt_r;
    if (in_valid && take) begin
      if (in_end_of_message) begin
        left_bits_nxt = '0;
        left_cnt_nxt  = '0;
      end else begin
        left_bits_nxt = rem_bits;
        left_cnt_nxt  = 3'(rem);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_bits_r <= '0;
      left_cnt_r  <= '0;
    end else begin
      left_bits_r <= left_bits_nxt;
      left_cnt_r  <= left_cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/b32e_fifo.sv =====
// ----------------------------------------------------------------------------
// b32e_fifo
// Small command queue between the front and back ends.
// ----------------------------------------------------------------------------
module b32e_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  b32e_pkg::b32e_cmd_t push_cmd,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output b32e_pkg::b32e_cmd_t head_cmd
);
  import b32e_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  b32e_cmd_t       mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic            do_push, do_pop;

  assign full       = (fill_r == CW'(DEPTH));
  assign head_valid = (fill_r != '0);
  assign head_cmd   = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + CW'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

// ===== rtl/core/b32e_back.sv =====
// ----------------------------------------------------------------------------
// b32e_back
// Sends one character per cycle from the queued commands while out_stall is
// low, adds padding and marks the last character of each message.
// ----------------------------------------------------------------------------
module b32e_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  b32e_pkg::b32e_cmd_t head_cmd,
  output logic                pop,
  output logic                out_valid,
  output logic [7:0]          out_char,
  output logic                out_last_char,
  input  logic                out_stall
);
  import b32e_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r;
  logic       out_last_r;
  logic       emit;
  logic       in_pad;
  logic       at_last_data;
  logic [2:0] pos_inc;
  logic [7:0] cur_char;
  logic       cur_last;
  logic       cmd_done;

  assign emit         = head_valid && (!out_valid_r || !out_stall);
  assign in_pad       = (idx_r >= head_cmd.cnt);
  assign at_last_data = (idx_r == head_cmd.cnt - 2'd1);
  assign pos_inc      = pos_r + 3'd1;

  always_comb begin
    if (in_pad) begin
      cur_char = PAD_CHAR;
      cur_last = (pos_inc == '0);
      cmd_done = cur_last;
    end else begin
      cur_char = head_cmd.chars[idx_r];
      cur_last = head_cmd.eom && at_last_data && (pos_inc == '0);
      cmd_done = at_last_data && (!head_cmd.eom || (pos_inc == '0));
    end
  end

  assign pop = emit && cmd_done;

  always_comb begin
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (emit) begin
      out_valid_nxt = 1'b1;
      pos_nxt       = pos_inc;
      if (cmd_done) begin
        idx_nxt = '0;
      end else if (!in_pad) begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r <= cur_char;
      out_last_r <= cur_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char      = out_char_r;
  assign out_last_char = out_last_r;

  // A message always closes on a group boundary.
  a_last_aligns: assert property (@(posedge clk) disable iff (!rst_n)
    emit && cur_last |=> pos_r == '0)
    else $error("last character not on a group boundary");

  // The character index never runs past the command's count.
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> idx_r <= head_cmd.cnt)
    else $error("character index beyond command count");

  // Padding belongs only to the end of a message.
  a_pad_eom: assert property (@(posedge clk) disable iff (!rst_n)
    emit && in_pad |-> head_cmd.eom)
    else $error("padding emitted outside end of message");

endmodule

// ===== rtl/core/base32_encoder_core.sv =====
// ----------------------------------------------------------------------------
// base32_encoder_core
// Streaming base32 encoder (A-Z, 2-7 alphabet) with '=' padding.
// ----------------------------------------------------------------------------
// Feed one message byte per input transfer and raise in_end_of_message on the
// final byte. Each byte yields one or two characters; the final byte also
// yields a flush character for any leftover bits and '=' padding up to a
// multiple of eight characters, with out_last_char set on the very last one.
// The output port sends one character per cycle while out_stall is low, and
// the final byte of a message yields up to eight characters. The front
// end takes a byte every cycle while the command queue (QUEUE_DEPTH entries)
// has room, so bursts of input are absorbed while characters drain. After
// reset the block is ready at once.
// ----------------------------------------------------------------------------
module base32_encoder_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_message,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_last_char
);
  import b32e_pkg::*;

  b32e_cmd_t front_cmd;
  b32e_cmd_t head_cmd;
  logic      q_full;
  logic      q_head_valid;
  logic      q_pop;
  logic      in_take;

  // Stall the input only while the command queue is full.
  assign in_stall = q_full;
  assign in_take  = !q_full;

  // Front: hold leftover bits, cut each byte into symbols.
  b32e_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .take              (in_take),
    .cmd               (front_cmd)
  );

  // Queue: decouple byte intake from character output.
  b32e_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (head_cmd)
  );

  // Back: advance one character per cycle, unless the output stalls, through a registered output.
  b32e_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (q_head_valid),
    .head_cmd      (head_cmd),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_char      (out_char),
    .out_last_char (out_last_char),
    .out_stall     (out_stall)
  );

endmodule

// ===== tb/base32_stream_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base32_stream_checker
// Watches both channels of the base32 encoder, predicts the character stream
// from every byte transfer and compares each character transfer against it.
// ----------------------------------------------------------------------------
module base32_stream_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_message,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_char,
  input  logic       out_last_char,
  output int         fail_count,
  output int         pending
);
  import b32e_pkg::*;

  localparam logic [8*32-1:0] ALPHABET = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } enc_char_t;

  enc_char_t  awaited_chars[$];
  logic [3:0] spare_bits = 4'd0;
  logic [2:0] spare_cnt  = 3'd0;
  logic [2:0] grp_pos    = 3'd0;
  int         errs       = 0;
  int         chars_seen = 0;

  function automatic logic [7:0] alpha_of(input logic [4:0] v);
    return ALPHABET[8*(31 - v) +: 8];
  endfunction

  task automatic flag_error(input string msg);
    $display("[%0t] checker: char #%0d %s", $time, chars_seen, msg);
    errs++;
  endtask

  // Advance the encoder state by one byte and queue the characters it yields.
  task automatic encode_byte(input logic [7:0] b, input logic eom);
    logic [7:0]  codes[8];
    logic [11:0] acc;
    logic [4:0]  sym;
    logic [3:0]  rem;
    logic [2:0]  pos;
    enc_char_t   item;
    int          nb;
    int          n;
    acc = {spare_bits, b};
    nb  = spare_cnt + 8;
    n   = 0;
    while (nb >= 5) begin
      nb -= 5;
      sym = 5'(acc >> nb);
      codes[n] = alpha_of(sym);
      n++;
    end
    rem = 4'(acc & ((12'd1 << nb) - 12'd1));
    if (eom) begin
      // flush leftover bits left-aligned, then pad the group out with '='
      if (nb > 0) begin
        sym = {1'b0, rem} << (5 - nb);
        codes[n] = alpha_of(sym);
        n++;
      end
      pos = grp_pos + n[2:0];
      while (pos != 3'd0 && n < 8) begin
        codes[n] = PAD_CHAR;
        n++;
        pos++;
      end
      spare_bits = 4'd0;
      spare_cnt  = 3'd0;
      grp_pos    = 3'd0;
    end else begin
      spare_bits = rem;
      spare_cnt  = nb[2:0];
      grp_pos    = grp_pos + n[2:0];
    end
    for (int i = 0; i < n; i++) begin
      item.code     = codes[i];
      item.last     = eom && (i == n - 1);
      awaited_chars = {awaited_chars, item};
    end
  endtask

  always @(posedge clk) begin : watch
    enc_char_t want;
    if (!rst_n) begin
      awaited_chars.delete();
      spare_bits = 4'd0;
      spare_cnt  = 3'd0;
      grp_pos    = 3'd0;
      chars_seen = 0;
      pending    <= 0;
      fail_count <= errs;
    end else begin
      if (in_valid && !in_stall) begin
        encode_byte(in_data_byte, in_end_of_message);
      end
      if (out_valid && !out_stall) begin
        if (awaited_chars.size() == 0) begin
          flag_error($sformatf("unexpected: char 0x%02h last %0b", out_char, out_last_char));
        end else begin
          want = awaited_chars.pop_front();
          if (out_char !== want.code) begin
            flag_error($sformatf("out_char 0x%02h, want 0x%02h", out_char, want.code));
          end
          if (out_last_char !== want.last) begin
            flag_error($sformatf("out_last_char %0b, want %0b", out_last_char, want.last));
          end
        end
        chars_seen++;
      end
      pending    <= awaited_chars.size();
      fail_count <= errs;
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for base32_encoder_core.
// Sends directed messages (all-zero, all-one and alternating bytes over every
// leftover length), then random messages under random idling on both sides,
// a long output hold-off and an idle-free stretch. A checker module beside
// the block predicts and compares every character.
// ----------------------------------------------------------------------------
module tb;

  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int ITEM_TARGET    = 205;

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_ALT} fill_t;

  logic       clk               = 1'b0;
  logic       rst_n             = 1'b0;
  logic       in_valid          = 1'b0;
  logic [7:0] in_data_byte      = 8'h00;
  logic       in_end_of_message = 1'b0;
  logic       out_stall         = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_char;
  logic       out_last_char;

  int fail_count;
  int pending;

  // Idling knobs: the sender's is used only by the stimulus process, the
  // receiver's is written with a nonblocking assignment so the sink sees it
  // cleanly at the edge.
  bit src_idle_on = 1'b0;
  bit snk_idle_on = 1'b0;

  // Hold-off handshake: the stimulus toggles hold_req, the sink acknowledges
  // and counts its own stall stretch.
  bit hold_req     = 1'b0;
  bit hold_ack     = 1'b0;
  int hold_left    = 0;
  int quiet_cycles = 0;
  int items_sent   = 0;

  always #1 clk = ~clk;

  base32_encoder_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_char          (out_char),
    .out_last_char     (out_last_char)
  );

  base32_stream_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_char          (out_char),
    .out_last_char     (out_last_char),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  // Receiver: one stall decision per edge. A hold-off request wins over the
  // random stalls and keeps out_stall high until hold_left has counted down.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= snk_idle_on && ($urandom_range(99) < 20);
    end
  end

  // Watchdog: count edges with no transfer on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Offer one byte and hold it until the transfer edge. An optional idle (valid
  // low) goes before the byte, never between raising valid and the transfer.
  task automatic send_byte(input logic [7:0] b, input logic eom);
    if (src_idle_on && ($urandom_range(99) < 20)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= b;
    in_end_of_message <= eom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // One message: len bytes, end_of_message on the last one.
  task automatic send_msg(input int len, input fill_t fill);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        FILL_ALT:  b = i[0] ? 8'h55 : 8'hAA;
        default:   b = $urandom_range(255);
      endcase
      send_byte(b, (i == len - 1));
    end
  endtask

  // Mostly short messages, now and then a longer one spanning several groups.
  task automatic send_random_msg();
    int len;
    len = ($urandom_range(7) == 0) ? $urandom_range(24, 11) : $urandom_range(10, 1);
    send_msg(len, FILL_RANDOM);
  endtask

  // Drop valid and wait until the checker has nothing outstanding. The first
  // edge lets the checker account for the transfer that just happened.
  task automatic drain_all();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every leftover length at the end (one to four bytes), a
    // message that exactly fills a group, and byte extremes.
    send_msg(1, FILL_ZERO);
    send_msg(1, FILL_ONES);
    send_msg(2, FILL_ALT);
    send_msg(3, FILL_ONES);
    send_msg(4, FILL_ZERO);
    send_msg(5, FILL_ONES);
    send_msg(5, FILL_ALT);
    drain_all();

    // Random messages with both sides idling now and then.
    src_idle_on = 1'b1;
    snk_idle_on <= 1'b1;
    while (items_sent < 100) send_random_msg();

    // Hold the output off while bytes keep coming so the block backs up and
    // stalls its input, then pause until every character is out.
    hold_req <= ~hold_req;
    send_msg(16, FILL_RANDOM);
    drain_all();

    // Long stretch at full rate on both sides.
    src_idle_on = 1'b0;
    snk_idle_on <= 1'b0;
    while (items_sent < 170) send_random_msg();

    src_idle_on = 1'b1;
    snk_idle_on <= 1'b1;
    while (items_sent < ITEM_TARGET) send_random_msg();

    drain_all();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
